@@ rtl/core/scan_sample_position_core_assert.svh @@
// assertion macros for the scan position rtl
`ifndef SCAN_SAMPLE_POSITION_CORE_ASSERT_SVH
`define SCAN_SAMPLE_POSITION_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SSP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssp assertion failed");

// consequent must hold a fixed number of cycles after the antecedent
`define SSP_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("ssp delayed assertion failed");

`endif

@@ rtl/core/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the scan sample position core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

    localparam int INDEX_BITS_DEF    = 12;
    localparam int COORD_BITS_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 20;

    localparam int FRAC_BITS  = 30;
    localparam int GUARD_BITS = 8;
    localparam int PHASE_BITS = 32;
    localparam int ZW         = 34;

    localparam logic [31:0] INV_GAIN = 32'd2608131496;

    // register map
    localparam logic [2:0] REG_SCAN_TYPE    = 3'd0;
    localparam logic [2:0] REG_START_X      = 3'd1;
    localparam logic [2:0] REG_START_Y      = 3'd2;
    localparam logic [2:0] REG_SECOND_X     = 3'd3;
    localparam logic [2:0] REG_SECOND_Y     = 3'd4;
    localparam logic [2:0] REG_CLOCKWISE    = 3'd5;
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd6;

    localparam logic [1:0] SCAN_LINE   = 2'd0;
    localparam logic [1:0] SCAN_CIRCLE = 2'd1;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] TURN_ATAN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_LINE,
        KIND_CIRCLE
    } kind_t;

    // control that travels with each word down the chain
    typedef struct packed {
        logic  vld;
        logic  err;
        logic  fz;
        kind_t kind;
    } tag_t;

endpackage

`default_nettype wire

@@ rtl/core/ssp_div_cell.sv @@
// ----------------------------------------------------------------------------
// ssp_div_cell
// One restoring division cell: resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_div_cell #(
    parameter int INDEX_BITS = ssp_pkg::INDEX_BITS_DEF,
    parameter int RW         = ssp_pkg::INDEX_BITS_DEF + ssp_pkg::FRAC_BITS + 1,
    parameter int QW         = ssp_pkg::FRAC_BITS + 1,
    parameter int SHIFT      = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [INDEX_BITS-1:0] divisor,
    input  wire ssp_pkg::tag_t         in_tag,
    input  wire logic [RW-1:0]         in_rem,
    input  wire logic [QW-1:0]         in_quo,
    output ssp_pkg::tag_t              out_tag,
    output logic [RW-1:0]              out_rem,
    output logic [QW-1:0]              out_quo
);

    ssp_pkg::tag_t   tag_reg;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [RW-1:0]   dsh;
    logic            take;

    // trial subtract of the shifted divisor
    assign dsh      = RW'(divisor) << SHIFT;
    assign take     = (in_rem >= dsh);
    assign rem_next = take ? (in_rem - dsh) : in_rem;
    assign quo_next = in_quo | (QW'(take) << SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign out_tag = tag_reg;
    assign out_rem = rem_reg;
    assign out_quo = quo_reg;

endmodule

`default_nettype wire

@@ rtl/core/ssp_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ssp_cordic_cell
// One CORDIC rotation micro-step on the radius vector.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_cordic_cell #(
    parameter int XW    = ssp_pkg::COORD_BITS_DEF + ssp_pkg::GUARD_BITS + 3,
    parameter int QW    = ssp_pkg::FRAC_BITS + 1,
    parameter int STAGE = 0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ssp_pkg::tag_t                in_tag,
    input  wire logic signed [XW-1:0]         in_x,
    input  wire logic signed [XW-1:0]         in_y,
    input  wire logic signed [ssp_pkg::ZW-1:0] in_z,
    input  wire logic [QW-1:0]                in_frac,
    output ssp_pkg::tag_t                     out_tag,
    output logic signed [XW-1:0]              out_x,
    output logic signed [XW-1:0]              out_y,
    output logic signed [ssp_pkg::ZW-1:0]     out_z,
    output logic [QW-1:0]                     out_frac
);

    localparam logic signed [ssp_pkg::ZW-1:0] ANG =
        ssp_pkg::ZW'(ssp_pkg::TURN_ATAN[STAGE]);

    ssp_pkg::tag_t                  tag_reg;
    logic signed [XW-1:0]           x_reg, x_next, y_reg, y_next;
    logic signed [ssp_pkg::ZW-1:0]  z_reg, z_next;
    logic [QW-1:0]                  frac_reg;
    logic signed [XW-1:0]           dx, dy;

    // rotate toward zero residual angle
    assign dx = in_y >>> STAGE;
    assign dy = in_x >>> STAGE;

    always_comb
    begin
        if (!in_z[ssp_pkg::ZW-1])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ANG;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        frac_reg <= in_frac;
    end

    assign out_tag  = tag_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_z    = z_reg;
    assign out_frac = frac_reg;

endmodule

`default_nettype wire

@@ rtl/core/ssp_out_stage.sv @@
// ----------------------------------------------------------------------------
// ssp_out_stage
// Gain correction, line interpolation, offset and circle saturation, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_out_stage #(
    parameter int COORD_BITS = ssp_pkg::COORD_BITS_DEF,
    parameter int XW         = ssp_pkg::COORD_BITS_DEF + ssp_pkg::GUARD_BITS + 3,
    parameter int QW         = ssp_pkg::FRAC_BITS + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ssp_pkg::tag_t                in_tag,
    input  wire logic signed [XW-1:0]         in_x,
    input  wire logic signed [XW-1:0]         in_y,
    input  wire logic [QW-1:0]                in_frac,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] second_x,
    input  wire logic signed [COORD_BITS-1:0] second_y,
    output logic                              done,
    output logic signed [COORD_BITS-1:0]      pos_x,
    output logic signed [COORD_BITS-1:0]      pos_y,
    output logic                              index_error
);

    localparam int CW   = COORD_BITS;
    localparam int MWP  = (XW > 32) ? XW : 33;
    localparam int RW2  = MWP + 1 - ssp_pkg::GUARD_BITS;
    localparam int SUMW = MWP + 3;
    localparam int LPW  = CW + 1 + QW;
    localparam logic signed [SUMW-1:0] MAXV = SUMW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SUMW-1:0] MINV = -MAXV - SUMW'(1);

    // stage 1: magnitudes and products
    ssp_pkg::tag_t   t1_reg;
    logic            xneg1_reg, yneg1_reg, lxneg1_reg, lyneg1_reg;
    logic [MWP-1:0]  xhi1_reg, yhi1_reg;
    logic [63:0]     xlo1_reg, ylo1_reg;
    logic [LPW-1:0]  lxp1_reg, lyp1_reg;

    logic signed [XW-1:0]  xabs, yabs;
    logic [MWP-1:0]        xmag, ymag;
    logic signed [CW:0]    ldx, ldy;
    logic [CW:0]           ldx_mag, ldy_mag;

    assign xabs    = in_x[XW-1] ? -in_x : in_x;
    assign yabs    = in_y[XW-1] ? -in_y : in_y;
    assign xmag    = MWP'($unsigned(xabs));
    assign ymag    = MWP'($unsigned(yabs));
    assign ldx     = (CW+1)'(second_x) - (CW+1)'(start_x);
    assign ldy     = (CW+1)'(second_y) - (CW+1)'(start_y);
    assign ldx_mag = ldx[CW] ? $unsigned(-ldx) : $unsigned(ldx);
    assign ldy_mag = ldy[CW] ? $unsigned(-ldy) : $unsigned(ldy);

    // stage 2: rounded magnitudes
    ssp_pkg::tag_t   t2_reg;
    logic            xneg2_reg, yneg2_reg, lxneg2_reg, lyneg2_reg;
    logic [RW2-1:0]  xr2_reg, yr2_reg;
    logic [CW:0]     lxr2_reg, lyr2_reg;

    logic [64:0]     xlo_rnd, ylo_rnd;
    logic [MWP:0]    xr, yr, xr_rnd, yr_rnd;
    logic [LPW:0]    lx_rnd, ly_rnd;

    assign xlo_rnd = {1'b0, xlo1_reg} + 65'h0_8000_0000;
    assign ylo_rnd = {1'b0, ylo1_reg} + 65'h0_8000_0000;
    assign xr      = (MWP+1)'(xhi1_reg) + (MWP+1)'(xlo_rnd[64:32]);
    assign yr      = (MWP+1)'(yhi1_reg) + (MWP+1)'(ylo_rnd[64:32]);
    assign xr_rnd  = xr + (MWP+1)'(1 << (ssp_pkg::GUARD_BITS - 1));
    assign yr_rnd  = yr + (MWP+1)'(1 << (ssp_pkg::GUARD_BITS - 1));
    assign lx_rnd  = (LPW+1)'(lxp1_reg) + (LPW+1)'(1 << (ssp_pkg::FRAC_BITS - 1));
    assign ly_rnd  = (LPW+1)'(lyp1_reg) + (LPW+1)'(1 << (ssp_pkg::FRAC_BITS - 1));

    // stage 3: sign, offset, saturate circle results
    logic signed [SUMW-1:0] xv, yv, xsum, ysum;
    logic signed [CW+1:0]   lxv, lyv, lxsum, lysum;
    logic signed [CW-1:0]   px_next, py_next;
    logic                   done_reg;
    logic signed [CW-1:0]   px_reg, py_reg;
    logic                   err_reg;

    assign xv    = xneg2_reg ? -SUMW'(xr2_reg) : SUMW'(xr2_reg);
    assign yv    = yneg2_reg ? -SUMW'(yr2_reg) : SUMW'(yr2_reg);
    assign xsum  = SUMW'(second_x) + xv;
    assign ysum  = SUMW'(second_y) + yv;
    assign lxv   = lxneg2_reg ? -(CW+2)'(lxr2_reg) : (CW+2)'(lxr2_reg);
    assign lyv   = lyneg2_reg ? -(CW+2)'(lyr2_reg) : (CW+2)'(lyr2_reg);
    assign lxsum = (CW+2)'(start_x) + lxv;
    assign lysum = (CW+2)'(start_y) + lyv;

    always_comb
    begin
        case (t2_reg.kind)
            ssp_pkg::KIND_LINE:
            begin
                px_next = lxsum[CW-1:0];
                py_next = lysum[CW-1:0];
            end
            ssp_pkg::KIND_CIRCLE:
            begin
                if (xsum > MAXV)
                    px_next = MAXV[CW-1:0];
                else if (xsum < MINV)
                    px_next = MINV[CW-1:0];
                else
                    px_next = xsum[CW-1:0];
                if (ysum > MAXV)
                    py_next = MAXV[CW-1:0];
                else if (ysum < MINV)
                    py_next = MINV[CW-1:0];
                else
                    py_next = ysum[CW-1:0];
            end
            default:
            begin
                px_next = '0;
                py_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            t1_reg   <= in_tag;
            t2_reg   <= t1_reg;
            done_reg <= t2_reg.vld;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        xneg1_reg  <= in_x[XW-1];
        yneg1_reg  <= in_y[XW-1];
        lxneg1_reg <= ldx[CW];
        lyneg1_reg <= ldy[CW];
        xhi1_reg   <= xmag[MWP-1:32] * ssp_pkg::INV_GAIN;
        yhi1_reg   <= ymag[MWP-1:32] * ssp_pkg::INV_GAIN;
        xlo1_reg   <= {32'b0, xmag[31:0]} * {32'b0, ssp_pkg::INV_GAIN};
        ylo1_reg   <= {32'b0, ymag[31:0]} * {32'b0, ssp_pkg::INV_GAIN};
        lxp1_reg   <= LPW'(ldx_mag) * LPW'(in_frac);
        lyp1_reg   <= LPW'(ldy_mag) * LPW'(in_frac);

        xneg2_reg  <= xneg1_reg;
        yneg2_reg  <= yneg1_reg;
        lxneg2_reg <= lxneg1_reg;
        lyneg2_reg <= lyneg1_reg;
        xr2_reg    <= xr_rnd[MWP:ssp_pkg::GUARD_BITS];
        yr2_reg    <= yr_rnd[MWP:ssp_pkg::GUARD_BITS];
        lxr2_reg   <= lx_rnd[ssp_pkg::FRAC_BITS+CW:ssp_pkg::FRAC_BITS];
        lyr2_reg   <= ly_rnd[ssp_pkg::FRAC_BITS+CW:ssp_pkg::FRAC_BITS];

        px_reg     <= px_next;
        py_reg     <= py_next;
        err_reg    <= t2_reg.err;
    end

    assign done        = done_reg;
    assign pos_x       = px_reg;
    assign pos_y       = py_reg;
    assign index_error = err_reg;

endmodule

`default_nettype wire

@@ rtl/core/scan_sample_position_core.sv @@
// ----------------------------------------------------------------------------
// scan_sample_position_core
// Position of one sample along a line or circle scan, Q16.16 millimetres.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  command   | start / busy               | sample_index
//  result    | done (one-cycle strobe)    | pos_x, pos_y, index_error
//  config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  One sample index is taken every cycle; busy is never raised.
//  Each index passes the entry register, the divider cells (one quotient bit
//  per cell), the quadrant fold register, the CORDIC cells and the out stage.
//  rst_n clears the pipeline valid bits and loads the register reset values.
//  The receiver cannot stall; each result is shown for one cycle under done.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_sample_position_core #(
    parameter int INDEX_BITS    = ssp_pkg::INDEX_BITS_DEF,
    parameter int COORD_BITS    = ssp_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = ssp_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [INDEX_BITS-1:0]        sample_index,
    output logic                              done,
    output logic signed [COORD_BITS-1:0]      pos_x,
    output logic signed [COORD_BITS-1:0]      pos_y,
    output logic                              index_error,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [COORD_BITS-1:0]        cfg_data
);

    localparam int FB      = ssp_pkg::FRAC_BITS;
    localparam int QW      = FB + 1;
    localparam int RW      = INDEX_BITS + FB + 1;
    localparam int XW      = COORD_BITS + ssp_pkg::GUARD_BITS + 3;
    localparam int PB      = ssp_pkg::PHASE_BITS;
    localparam int ZW      = ssp_pkg::ZW;
    localparam int LATENCY = 1 + QW + 1 + CORDIC_STAGES + 3;

    // configuration registers
    logic [1:0]                   scan_type_reg;
    logic signed [COORD_BITS-1:0] start_x_reg, start_y_reg, second_x_reg, second_y_reg;
    logic                         clockwise_reg;
    logic [INDEX_BITS:0]          sample_count_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_type_reg    <= '0;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            second_x_reg     <= '0;
            second_y_reg     <= '0;
            clockwise_reg    <= 1'b1;
            sample_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssp_pkg::REG_SCAN_TYPE:    scan_type_reg    <= cfg_data[1:0];
                ssp_pkg::REG_START_X:      start_x_reg      <= cfg_data;
                ssp_pkg::REG_START_Y:      start_y_reg      <= cfg_data;
                ssp_pkg::REG_SECOND_X:     second_x_reg     <= cfg_data;
                ssp_pkg::REG_SECOND_Y:     second_y_reg     <= cfg_data;
                ssp_pkg::REG_CLOCKWISE:    clockwise_reg    <= cfg_data[0];
                ssp_pkg::REG_SAMPLE_COUNT: sample_count_reg <= (INDEX_BITS+1)'(cfg_data);
                default: ;
            endcase
        end
    end

    // divisor is count - 1; the user must keep it fixed while words are in flight, the block does not enforce it
    logic [INDEX_BITS:0]   count_m1;
    logic [INDEX_BITS-1:0] divisor;

    assign count_m1 = sample_count_reg - (INDEX_BITS+1)'(1);
    assign divisor  = count_m1[INDEX_BITS-1:0];

    // entry register: classify the word and form the rounded dividend
    ssp_pkg::tag_t  tag_next, ent_tag_reg;
    logic [RW-1:0]  ent_rem_reg, rem_next;

    always_comb
    begin
        tag_next.vld  = start && !busy;
        tag_next.err  = ((INDEX_BITS+1)'(sample_index) >= sample_count_reg);
        tag_next.fz   = (sample_count_reg <= (INDEX_BITS+1)'(1));
        if (tag_next.err)
            tag_next.kind = ssp_pkg::KIND_ZERO;
        else if (scan_type_reg == ssp_pkg::SCAN_LINE)
            tag_next.kind = ssp_pkg::KIND_LINE;
        else if (scan_type_reg == ssp_pkg::SCAN_CIRCLE)
            tag_next.kind = ssp_pkg::KIND_CIRCLE;
        else
            tag_next.kind = ssp_pkg::KIND_ZERO;
        rem_next = (RW'(sample_index) << FB) + RW'(divisor >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_tag_reg <= '0;
        end
        else
        begin
            ent_tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_rem_reg <= rem_next;
    end

    // divider cell chain, most significant quotient bit first
    ssp_pkg::tag_t  div_tag [QW+1];
    logic [RW-1:0]  div_rem [QW+1];
    logic [QW-1:0]  div_quo [QW+1];

    assign div_tag[0] = ent_tag_reg;
    assign div_rem[0] = ent_rem_reg;
    assign div_quo[0] = '0;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        ssp_div_cell #(
            .INDEX_BITS (INDEX_BITS),
            .RW         (RW),
            .QW         (QW),
            .SHIFT      (QW - 1 - j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .divisor (divisor),
            .in_tag  (div_tag[j]),
            .in_rem  (div_rem[j]),
            .in_quo  (div_quo[j]),
            .out_tag (div_tag[j+1]),
            .out_rem (div_rem[j+1]),
            .out_quo (div_quo[j+1])
        );
    end

    // quadrant fold: phase in turns, radius vector pre-rotated by quarters
    logic [QW-1:0]              frac;
    logic [PB-1:0]              phase, phase_dir, phase_bias, phase_res;
    logic [1:0]                 quad;
    logic signed [COORD_BITS:0] rdx, rdy;
    logic signed [XW-1:0]       x0, y0, xq, yq;

    assign frac       = div_tag[QW].fz ? '0 : div_quo[QW];
    assign phase      = PB'(frac) << (PB - FB);
    assign phase_dir  = clockwise_reg ? phase : (PB'(0) - phase);
    assign phase_bias = phase_dir + (PB'(1) << (PB - 3));
    assign quad       = phase_bias[PB-1:PB-2];
    assign phase_res  = phase_dir - ({quad, {(PB-2){1'b0}}});
    assign rdx        = (COORD_BITS+1)'(start_x_reg) - (COORD_BITS+1)'(second_x_reg);
    assign rdy        = (COORD_BITS+1)'(start_y_reg) - (COORD_BITS+1)'(second_y_reg);
    assign x0         = XW'(rdx) <<< ssp_pkg::GUARD_BITS;
    assign y0         = XW'(rdy) <<< ssp_pkg::GUARD_BITS;

    always_comb
    begin
        case (quad)
            2'd1:
            begin
                xq = -y0;
                yq = x0;
            end
            2'd2:
            begin
                xq = -x0;
                yq = -y0;
            end
            2'd3:
            begin
                xq = y0;
                yq = -x0;
            end
            default:
            begin
                xq = x0;
                yq = y0;
            end
        endcase
    end

    ssp_pkg::tag_t        fold_tag_reg;
    logic signed [XW-1:0] fold_x_reg, fold_y_reg;
    logic signed [ZW-1:0] fold_z_reg;
    logic [QW-1:0]        fold_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_tag_reg <= '0;
        end
        else
        begin
            fold_tag_reg <= div_tag[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        fold_x_reg    <= xq;
        fold_y_reg    <= yq;
        fold_z_reg    <= ZW'($signed(phase_res));
        fold_frac_reg <= frac;
    end

    // cordic cell chain
    ssp_pkg::tag_t        cor_tag  [CORDIC_STAGES+1];
    logic signed [XW-1:0] cor_x    [CORDIC_STAGES+1];
    logic signed [XW-1:0] cor_y    [CORDIC_STAGES+1];
    logic signed [ZW-1:0] cor_z    [CORDIC_STAGES+1];
    logic [QW-1:0]        cor_frac [CORDIC_STAGES+1];

    assign cor_tag[0]  = fold_tag_reg;
    assign cor_x[0]    = fold_x_reg;
    assign cor_y[0]    = fold_y_reg;
    assign cor_z[0]    = fold_z_reg;
    assign cor_frac[0] = fold_frac_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        ssp_cordic_cell #(
            .XW    (XW),
            .QW    (QW),
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_tag   (cor_tag[i]),
            .in_x     (cor_x[i]),
            .in_y     (cor_y[i]),
            .in_z     (cor_z[i]),
            .in_frac  (cor_frac[i]),
            .out_tag  (cor_tag[i+1]),
            .out_x    (cor_x[i+1]),
            .out_y    (cor_y[i+1]),
            .out_z    (cor_z[i+1]),
            .out_frac (cor_frac[i+1])
        );
    end

    // gain correction, line interpolation and result register
    ssp_out_stage #(
        .COORD_BITS (COORD_BITS),
        .XW         (XW),
        .QW         (QW)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_tag      (cor_tag[CORDIC_STAGES]),
        .in_x        (cor_x[CORDIC_STAGES]),
        .in_y        (cor_y[CORDIC_STAGES]),
        .in_frac     (cor_frac[CORDIC_STAGES]),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .second_x    (second_x_reg),
        .second_y    (second_y_reg),
        .done        (done),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .index_error (index_error)
    );

    // checks
`include "scan_sample_position_core_assert.svh"

    `SSP_ASSERT_DELAY(a_start_gives_done, start && !busy, LATENCY, done)
    `SSP_ASSERT_DELAY(a_no_start_no_done, !(start && !busy), LATENCY, !done)
    `SSP_ASSERT_IMPL(a_error_at_origin, done && index_error, pos_x == '0 && pos_y == '0)

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scan_sample_position_core. Registers are written
// between phases while the pipeline is empty. Sample indexes are sent
// back to back or with random gaps. Every done word is compared against
// a bit-exact line/circle position predictor in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

    localparam logic [1:0] SCAN_OTHER = 2'd2;
    localparam logic [1:0] SCAN_RSVD  = 2'd3;
    localparam int PIPE_DEPTH = 1 + (ssp_pkg::FRAC_BITS + 1) + 1
                                + ssp_pkg::CORDIC_STAGES_DEF + 3;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        err;
    } position_t;

    // position predictor and store of pending positions
    class position_board;
        logic [1:0]  kind;
        longint      sx, sy, ex, ey;
        bit          cw;
        longint      count;
        position_t   pending[$];
        int          fails;
        int          matched;

        function new();
            kind = ssp_pkg::SCAN_LINE; sx = 0; sy = 0; ex = 0; ey = 0; cw = 1; count = 0;
            fails = 0; matched = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fails++;
        endtask

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                ssp_pkg::REG_SCAN_TYPE:    kind = data[1:0];
                ssp_pkg::REG_START_X:      sx = longint'($signed(data));
                ssp_pkg::REG_START_Y:      sy = longint'($signed(data));
                ssp_pkg::REG_SECOND_X:     ex = longint'($signed(data));
                ssp_pkg::REG_SECOND_Y:     ey = longint'($signed(data));
                ssp_pkg::REG_CLOCKWISE:    cw = data[0];
                ssp_pkg::REG_SAMPLE_COUNT: count = longint'(data[12:0]);
                default: ;
            endcase
        endfunction

        // round(a*m / 2^sh), ties away from zero
        function longint mul_rnd(longint a, longint unsigned m, int sh);
            bit neg;
            longint unsigned mag, hi, lo, r;
            neg = a < 0;
            mag = neg ? longint'(-a) : a;
            hi = (mag >> 32) * m;
            lo = (mag & 64'hFFFF_FFFF) * m;
            r = (hi << (32 - sh)) + ((lo + (64'd1 << (sh - 1))) >> sh);
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint shr_rnd(longint v, int sh);
            bit neg;
            longint unsigned mag, r;
            neg = v < 0;
            mag = neg ? longint'(-v) : v;
            r = (mag + (64'd1 << (sh - 1))) >> sh;
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // rotate the radius vector by frac turns with the cordic
        function void circle(longint unsigned frac, output longint px, output longint py);
            longint x, y, z, t, dx, dy;
            logic [31:0] phase, q, res;
            x = (sx - ex) * (64'sd1 <<< ssp_pkg::GUARD_BITS);
            y = (sy - ey) * (64'sd1 <<< ssp_pkg::GUARD_BITS);
            phase = 32'(frac << (32 - ssp_pkg::FRAC_BITS));
            if (!cw) phase = 32'd0 - phase;
            q = ((phase + 32'h2000_0000) >> 30) & 32'd3;
            res = phase - (q << 30);
            z = longint'($signed(res));
            if (q == 1) begin t = x; x = -y; y = t; end
            else if (q == 2) begin x = -x; y = -y; end
            else if (q == 3) begin t = x; x = y; y = -t; end
            for (int i = 0; i < ssp_pkg::CORDIC_STAGES_DEF; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= longint'(ssp_pkg::TURN_ATAN[i]);
                end
                else
                begin
                    x += dx; y -= dy; z += longint'(ssp_pkg::TURN_ATAN[i]);
                end
            end
            x = shr_rnd(mul_rnd(x, ssp_pkg::INV_GAIN, 32), ssp_pkg::GUARD_BITS);
            y = shr_rnd(mul_rnd(y, ssp_pkg::INV_GAIN, 32), ssp_pkg::GUARD_BITS);
            px = sat(ex + x);
            py = sat(ey + y);
        endfunction

        function void note_index(logic [11:0] idx);
            position_t p;
            longint unsigned frac, d;
            longint px, py;
            frac = 0; px = 0; py = 0;
            p.err = 0;
            if (longint'(idx) >= count)
                p.err = 1;
            else
            begin
                if (count > 1)
                begin
                    d = count - 1;
                    frac = ((longint'(idx) << ssp_pkg::FRAC_BITS) + (d >> 1)) / d;
                end
                if (kind == ssp_pkg::SCAN_LINE)
                begin
                    px = sx + mul_rnd(ex - sx, frac, ssp_pkg::FRAC_BITS);
                    py = sy + mul_rnd(ey - sy, frac, ssp_pkg::FRAC_BITS);
                end
                else if (kind == ssp_pkg::SCAN_CIRCLE)
                    circle(frac, px, py);
            end
            p.x = px[31:0];
            p.y = py[31:0];
            pending.push_back(p);
        endfunction

        task check_result(logic [31:0] x, logic [31:0] y, logic err);
            position_t p;
            if (pending.size() == 0)
            begin
                report("position word with nothing pending");
                return;
            end
            p = pending.pop_front();
            if (x !== p.x || y !== p.y || err !== p.err)
                report($sformatf("got x=%h y=%h err=%b, want x=%h y=%h err=%b",
                                 x, y, err, p.x, p.y, p.err));
            else
                matched++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [11:0] sample_index;
    logic        done;
    logic signed [31:0] pos_x, pos_y;
    logic        index_error;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    position_board board;
    int gap_pct;
    int sent;
    int idle_cycles;
    int circle_items;

    scan_sample_position_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_index(sample_index), .done(done), .pos_x(pos_x), .pos_y(pos_y),
        .index_error(index_error), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_index(sample_index);
            if (done)
                board.check_result(pos_x, pos_y, index_error);
            if ((start && !busy) || (cfg_valid && cfg_ready) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic send_index(logic [11:0] idx);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 0;
        end
        @(negedge clk);
        start <= 1;
        sample_index <= idx;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_scan(logic [1:0] kind, logic [31:0] ax, logic [31:0] ay,
                            logic [31:0] bx, logic [31:0] by, logic dir, logic [12:0] n);
        write_reg(ssp_pkg::REG_SCAN_TYPE, 32'(kind));
        write_reg(ssp_pkg::REG_START_X, ax);
        write_reg(ssp_pkg::REG_START_Y, ay);
        write_reg(ssp_pkg::REG_SECOND_X, bx);
        write_reg(ssp_pkg::REG_SECOND_Y, by);
        write_reg(ssp_pkg::REG_CLOCKWISE, 32'(dir));
        write_reg(ssp_pkg::REG_SAMPLE_COUNT, 32'(n));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(200 << 16)) - (100 << 16));
        endcase
    endfunction

    function automatic logic [12:0] rand_count();
        case ($urandom_range(7))
            0: return 13'($urandom_range(2));
            1: return 13'd4096;
            2: return 13'($urandom_range(4096));
            default: return 13'($urandom_range(3, 64));
        endcase
    endfunction

    initial
    begin
        logic [12:0] n;
        logic [1:0]  kind;
        board = new();
        start = 0; sample_index = 0; cfg_valid = 0; cfg_index = ssp_pkg::REG_SCAN_TYPE;
        cfg_data = 0; gap_pct = 0; sent = 0; idle_cycles = 0; circle_items = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset state: count zero so every index is out of range
        send_index(0);
        send_index(12'hFFF);
        drain();

        // line between the coordinate extremes, largest count
        set_scan(ssp_pkg::SCAN_LINE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 1, 13'd4096);
        send_index(0); send_index(2048); send_index(4095);
        drain();
        // single sample gives the start, index one is out of range
        write_reg(ssp_pkg::REG_SAMPLE_COUNT, 32'd1);
        send_index(0); send_index(1);
        drain();
        // circle both directions, degenerate circle, saturating circle
        set_scan(ssp_pkg::SCAN_CIRCLE, 32'h000A_0000, 32'h0, 32'h0, 32'h0, 1, 13'd5);
        for (int i = 0; i < 6; i++) send_index(12'(i));
        drain();
        write_reg(ssp_pkg::REG_CLOCKWISE, 32'd0);
        for (int i = 0; i < 5; i++) send_index(12'(i));
        drain();
        set_scan(ssp_pkg::SCAN_CIRCLE, 32'h0012_0000, 32'hFFF0_0000, 32'h0012_0000,
                 32'hFFF0_0000, 1, 13'd3);
        send_index(1);
        drain();
        set_scan(ssp_pkg::SCAN_CIRCLE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 0, 13'd4);
        send_index(1); send_index(2);
        drain();
        // unknown scan types give the origin
        write_reg(ssp_pkg::REG_SCAN_TYPE, 32'(SCAN_OTHER));
        send_index(0); send_index(4);
        drain();
        write_reg(ssp_pkg::REG_SCAN_TYPE, 32'(SCAN_RSVD));
        send_index(3);
        drain();

        // random phases with fresh settings and varied sender gaps
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: gap_pct = 0;
                1: gap_pct = 46;
                2: gap_pct = 0;
                default: gap_pct = 26;
            endcase
            n = rand_count();
            kind = ($urandom_range(9) < 9) ? 2'($urandom_range(1))
                                           : ($urandom_range(1) ? SCAN_OTHER : SCAN_RSVD);
            set_scan(kind, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     1'($urandom_range(1)), n);
            for (int k = 0; k < 70; k++)
            begin
                if (kind == ssp_pkg::SCAN_CIRCLE) circle_items++;
                if ($urandom_range(9) == 0 || n == 0)
                    send_index(12'($urandom()));
                else
                    send_index(12'($urandom_range(n - 1)));
            end
            drain();
        end

        repeat (PIPE_DEPTH + 8) @(posedge clk);
        $display("covered %0d indexes (%0d on circles), %0d positions matched",
                 sent, circle_items, board.matched);
        if (board.fails == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

@@ scan_sample_position_core.f @@
+incdir+rtl/core
rtl/core/ssp_pkg.sv
rtl/core/ssp_div_cell.sv
rtl/core/ssp_cordic_cell.sv
rtl/core/ssp_out_stage.sv
rtl/core/scan_sample_position_core.sv
sim/tb.sv
